/* rtl/csvp_pkg.sv */
package csvp_pkg;

    // Default width of the row counter
    localparam int COUNT_WIDTH_DEF = 32;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int ROW_W     = 32;
    localparam int COL_W     = 16;
    localparam int LEN_W     = 12;
    localparam int CAP_W     = 13;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'd34;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_CAPACITY = 2'd1;

    // Register reset values
    localparam logic [BYTE_W-1:0] DELIMITER_RST  = 8'd44;
    localparam logic [LEN_W-1:0]  KEEP_LIMIT_RST = 12'd127;
    localparam logic [LEN_W-1:0]  KEEP_LIMIT_MAX = 12'd4095;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CONTENT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIELD_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT_DONE = 2'd2;

    // Output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef enum logic [2:0] {
        PH_RECORD = 3'd0,
        PH_FIELD  = 3'd1,
        PH_PLAIN  = 3'd2,
        PH_QUOTED = 3'd3,
        PH_QSEEN  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] content_byte;
        logic [ROW_W-1:0]  row_index;
        logic [COL_W-1:0]  column_index;
        logic [LEN_W-1:0]  field_length;
        logic              last_in_row;
        logic              empty_row;
        logic [ROW_W-1:0]  record_count;
        logic              last_of_run;
    } t_result;

    // Up to two results per request, handed to the output queue
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_core_out;

endpackage

/* rtl/csvp_core.sv */
module csvp_core #(
    parameter int COUNT_WIDTH = csvp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [csvp_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_eot,
    input  logic [csvp_pkg::BYTE_W-1:0]   i_delimiter,
    input  logic [csvp_pkg::LEN_W-1:0]    i_keep_limit,
    output csvp_pkg::t_core_out           o_out
);

    csvp_pkg::t_phase               r_phase, n_phase;
    logic                           r_after_cr, n_after_cr;
    logic [COUNT_WIDTH-1:0]         r_row, n_row;
    logic [csvp_pkg::COL_W-1:0]     r_col, n_col;
    logic [csvp_pkg::LEN_W-1:0]     r_len, n_len;

    logic [COUNT_WIDTH-1:0]         row_inc;
    logic                           is_term;
    logic                           is_quote;
    logic                           is_delim;
    logic                           act_plain;
    logic                           act_add;
    logic [csvp_pkg::BYTE_W-1:0]    add_val;
    logic                           end_any;
    logic                           end_last;
    csvp_pkg::t_result              res0, res1;
    logic [1:0]                     num;

    assign row_inc  = r_row + COUNT_WIDTH'(1);
    assign is_term  = (i_byte == csvp_pkg::CH_LF) || (i_byte == csvp_pkg::CH_CR);
    assign is_quote = (i_byte == csvp_pkg::CH_QUOTE);
    assign is_delim = (i_byte == i_delimiter);

    // Parser step: next state and up to two results
    always_comb begin
        n_phase    = r_phase;
        n_after_cr = r_after_cr;
        n_row      = r_row;
        n_col      = r_col;
        n_len      = r_len;
        res0       = '0;
        res1       = '0;
        num        = 2'd0;
        act_plain  = 1'b0;
        act_add    = 1'b0;
        add_val    = i_byte;
        end_any    = 1'b0;
        end_last   = 1'b0;
        if (i_go) begin
            if (i_eot) begin
                // close an open field, report records, restart counts
                if (r_phase != csvp_pkg::PH_RECORD) begin
                    res0.kind         = csvp_pkg::KIND_FIELD_END;
                    res0.row_index    = csvp_pkg::ROW_W'(r_row);
                    res0.column_index = r_col;
                    res0.field_length = r_len;
                    res0.last_in_row  = 1'b1;
                    res1.kind         = csvp_pkg::KIND_TEXT_DONE;
                    res1.record_count = csvp_pkg::ROW_W'(row_inc);
                    res1.last_of_run  = 1'b1;
                    num               = 2'd2;
                end else begin
                    res0.kind         = csvp_pkg::KIND_TEXT_DONE;
                    res0.record_count = csvp_pkg::ROW_W'(r_row);
                    res0.last_of_run  = 1'b1;
                    num               = 2'd1;
                end
                n_phase    = csvp_pkg::PH_RECORD;
                n_after_cr = 1'b0;
                n_row      = '0;
                n_col      = '0;
                n_len      = '0;
            end else if (r_after_cr && (i_byte == csvp_pkg::CH_LF)) begin
                // LF of a CRLF pair is swallowed
                n_after_cr = 1'b0;
            end else begin
                n_after_cr = 1'b0;
                case (r_phase)
                    csvp_pkg::PH_RECORD: begin
                        if (is_term) begin
                            // blank line
                            res0.kind        = csvp_pkg::KIND_FIELD_END;
                            res0.row_index   = csvp_pkg::ROW_W'(r_row);
                            res0.last_in_row = 1'b1;
                            res0.empty_row   = 1'b1;
                            num              = 2'd1;
                            n_row            = row_inc;
                            n_col            = '0;
                            n_len            = '0;
                            n_after_cr       = (i_byte == csvp_pkg::CH_CR);
                        end else if (is_quote) begin
                            n_phase = csvp_pkg::PH_QUOTED;
                        end else begin
                            act_plain = 1'b1;
                        end
                    end
                    csvp_pkg::PH_FIELD: begin
                        if (is_quote) begin
                            n_phase = csvp_pkg::PH_QUOTED;
                        end else begin
                            act_plain = 1'b1;
                        end
                    end
                    csvp_pkg::PH_PLAIN: begin
                        act_plain = 1'b1;
                    end
                    csvp_pkg::PH_QUOTED: begin
                        if (is_quote) begin
                            n_phase = csvp_pkg::PH_QSEEN;
                        end else begin
                            act_add = 1'b1;
                        end
                    end
                    csvp_pkg::PH_QSEEN: begin
                        if (is_quote) begin
                            // doubled quote: one literal quote
                            n_phase = csvp_pkg::PH_QUOTED;
                            act_add = 1'b1;
                            add_val = csvp_pkg::CH_QUOTE;
                        end else begin
                            act_plain = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = csvp_pkg::PH_RECORD;
                    end
                endcase

                // unquoted byte: delimiter first, then terminators
                if (act_plain) begin
                    if (is_delim) begin
                        end_any = 1'b1;
                    end else if (is_term) begin
                        end_any    = 1'b1;
                        end_last   = 1'b1;
                        n_after_cr = (i_byte == csvp_pkg::CH_CR);
                    end else begin
                        n_phase = csvp_pkg::PH_PLAIN;
                        act_add = 1'b1;
                    end
                end

                if (end_any) begin
                    res0.kind         = csvp_pkg::KIND_FIELD_END;
                    res0.row_index    = csvp_pkg::ROW_W'(r_row);
                    res0.column_index = r_col;
                    res0.field_length = r_len;
                    res0.last_in_row  = end_last;
                    num               = 2'd1;
                    n_len             = '0;
                    if (end_last) begin
                        n_col   = '0;
                        n_row   = row_inc;
                        n_phase = csvp_pkg::PH_RECORD;
                    end else begin
                        if (r_col != {csvp_pkg::COL_W{1'b1}}) begin
                            n_col = r_col + csvp_pkg::COL_W'(1);
                        end
                        n_phase = csvp_pkg::PH_FIELD;
                    end
                end

                // keep the byte while the field has room
                if (act_add && (r_len < i_keep_limit)) begin
                    res0.kind         = csvp_pkg::KIND_CONTENT;
                    res0.content_byte = add_val;
                    res0.row_index    = csvp_pkg::ROW_W'(r_row);
                    res0.column_index = r_col;
                    num               = 2'd1;
                    n_len             = r_len + csvp_pkg::LEN_W'(1);
                end

                res0.last_of_run = (num != 2'd0);
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= csvp_pkg::PH_RECORD;
            r_after_cr <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_len      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_after_cr <= n_after_cr;
            r_row      <= n_row;
            r_col      <= n_col;
            r_len      <= n_len;
        end
    end

    assign o_out.num  = num;
    assign o_out.res0 = res0;
    assign o_out.res1 = res1;

    // CR pending only between records
    a_cr_at_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_after_cr |-> (r_phase == csvp_pkg::PH_RECORD))
        else $error("CR pending outside record start");

    // two results only for the end of text, text done last
    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (num == 2'd2) |-> (i_go && i_eot && res1.last_of_run && !res0.last_of_run
                           && (res1.kind == csvp_pkg::KIND_TEXT_DONE)))
        else $error("bad double result");

    // end of text restarts the row, column and length counts
    a_col_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_eot) |=> (r_row == '0) && (r_col == '0) && (r_len == '0))
        else $error("counts not restarted after end of text");

endmodule

/* rtl/csvp_outq.sv */
module csvp_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  csvp_pkg::t_core_out   i_data,
    input  logic                  i_pop,
    output logic                  o_room,
    output logic                  o_valid,
    output csvp_pkg::t_result     o_data
);

    csvp_pkg::t_result               mem [csvp_pkg::OQ_DEPTH];
    logic [csvp_pkg::OQ_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [csvp_pkg::OQ_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [csvp_pkg::OQ_CNT_W-1:0]   r_count, n_count;
    logic [csvp_pkg::OQ_CNT_W-1:0]   push_num;
    logic                            pop_ok;

    assign push_num = i_push ? csvp_pkg::OQ_CNT_W'(i_data.num) : '0;
    assign pop_ok   = i_pop && (r_count != '0);
    assign n_wr_ptr = r_wr_ptr + csvp_pkg::OQ_PTR_W'(push_num);
    assign n_rd_ptr = r_rd_ptr + csvp_pkg::OQ_PTR_W'(pop_ok);
    assign n_count  = r_count + push_num - csvp_pkg::OQ_CNT_W'(pop_ok);

    // space for the worst case of two results
    assign o_room  = (r_count <= csvp_pkg::OQ_CNT_W'(csvp_pkg::OQ_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_num != '0) begin
            mem[r_wr_ptr] <= i_data.res0;
        end
        if (push_num == csvp_pkg::OQ_CNT_W'(2)) begin
            mem[r_wr_ptr + csvp_pkg::OQ_PTR_W'(1)] <= i_data.res1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_num != '0) |-> o_room)
        else $error("output queue pushed without room");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[csvp_pkg::OQ_PTR_W-1:0])
        else $error("output queue pointers disagree with count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= csvp_pkg::OQ_CNT_W'(csvp_pkg::OQ_DEPTH))
        else $error("output queue count beyond depth");

endmodule

/* rtl/csv_field_parser.sv */
// A request passes through the input register; the parser step then writes its
// results into the output queue, from which they are offered.
// Throughput: one request per cycle; the input stalls only while a request waits
// in the input register and the output queue holds three or more results.
// End of text gives up to two results, one per cycle unless the receiver stalls.
// Reset (synchronous, active low) clears the parser state, counters and queue
// and restores delimiter 44 and field capacity 128.
module csv_field_parser #(
    parameter int COUNT_WIDTH = csvp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [csvp_pkg::BYTE_W-1:0]     i_text_byte,
    input  logic                            i_end_of_text,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [csvp_pkg::KIND_W-1:0]     o_kind,
    output logic [csvp_pkg::BYTE_W-1:0]     o_content_byte,
    output logic [csvp_pkg::ROW_W-1:0]      o_row_index,
    output logic [csvp_pkg::COL_W-1:0]      o_column_index,
    output logic [csvp_pkg::LEN_W-1:0]      o_field_length,
    output logic                            o_last_in_row,
    output logic                            o_empty_row,
    output logic [csvp_pkg::ROW_W-1:0]      o_record_count,
    output logic                            o_last_of_run,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [csvp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [csvp_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    logic                            r_in_valid;
    logic [csvp_pkg::BYTE_W-1:0]     r_in_byte;
    logic                            r_in_eot;
    logic [csvp_pkg::BYTE_W-1:0]     r_delimiter;
    logic [csvp_pkg::LEN_W-1:0]      r_keep_limit, n_keep_limit;
    logic [csvp_pkg::CAP_W-1:0]      cap_less;
    logic                            in_take;
    logic                            core_go;
    logic                            q_room;
    csvp_pkg::t_core_out             core_out;
    csvp_pkg::t_result               q_data;

    assign core_go    = r_in_valid && q_room;
    assign o_in_stall = r_in_valid && !q_room;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (core_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    // Keep limit: capacity minus one, zero treated as one, capped at 4095
    assign cap_less = i_cfg_data - csvp_pkg::CAP_W'(1);
    always_comb begin
        if (i_cfg_data == '0) begin
            n_keep_limit = '0;
        end else if (cap_less[csvp_pkg::CAP_W-1]) begin
            n_keep_limit = csvp_pkg::KEEP_LIMIT_MAX;
        end else begin
            n_keep_limit = cap_less[csvp_pkg::LEN_W-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter  <= csvp_pkg::DELIMITER_RST;
            r_keep_limit <= csvp_pkg::KEEP_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                csvp_pkg::CFG_DELIMITER: begin
                    r_delimiter <= i_cfg_data[csvp_pkg::BYTE_W-1:0];
                end
                csvp_pkg::CFG_FIELD_CAPACITY: begin
                    r_keep_limit <= n_keep_limit;
                end
                default: begin
                end
            endcase
        end
    end

    csvp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (core_go),
        .i_byte       (r_in_byte),
        .i_eot        (r_in_eot),
        .i_delimiter  (r_delimiter),
        .i_keep_limit (r_keep_limit),
        .o_out        (core_out)
    );

    csvp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_go),
        .i_data  (core_out),
        .i_pop   (!i_out_stall),
        .o_room  (q_room),
        .o_valid (o_out_valid),
        .o_data  (q_data)
    );

    assign o_kind         = q_data.kind;
    assign o_content_byte = q_data.content_byte;
    assign o_row_index    = q_data.row_index;
    assign o_column_index = q_data.column_index;
    assign o_field_length = q_data.field_length;
    assign o_last_in_row  = q_data.last_in_row;
    assign o_empty_row    = q_data.empty_row;
    assign o_record_count = q_data.record_count;
    assign o_last_of_run  = q_data.last_of_run;

endmodule

/* tb/sv/csv_field_parser_checker.sv */
module csv_field_parser_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [csvp_pkg::BYTE_W-1:0]     i_text_byte,
    input  logic                            i_end_of_text,
    // result channel
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [csvp_pkg::KIND_W-1:0]     i_kind,
    input  logic [csvp_pkg::BYTE_W-1:0]     i_content_byte,
    input  logic [csvp_pkg::ROW_W-1:0]      i_row_index,
    input  logic [csvp_pkg::COL_W-1:0]      i_column_index,
    input  logic [csvp_pkg::LEN_W-1:0]      i_field_length,
    input  logic                            i_last_in_row,
    input  logic                            i_empty_row,
    input  logic [csvp_pkg::ROW_W-1:0]      i_record_count,
    input  logic                            i_last_of_run,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [csvp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [csvp_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // status to the testbench top
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import csvp_pkg::*;

    // Parser state as predicted
    t_phase             phase_q;
    logic               after_cr_q;
    logic [ROW_W-1:0]   row_q;
    logic [COL_W-1:0]   col_q;
    logic [LEN_W-1:0]   kept_q;
    logic [BYTE_W-1:0]  delim_q;
    logic [CAP_W-1:0]   cap_q;

    // Results of one request, then the queue of results still owed by the block
    t_result            step_res [2];
    int                 step_n;
    t_result            owed_results [$];
    int                 failures = 0;

    function automatic string result_text(t_result r);
        return $sformatf({"kind %0d byte %02h row %0d col %0d len %0d ",
                          "last %0b empty %0b cnt %0d lor %0b"},
                         r.kind, r.content_byte, r.row_index, r.column_index,
                         r.field_length, r.last_in_row, r.empty_row, r.record_count,
                         r.last_of_run);
    endfunction

    task automatic report_failure(string what, t_result want, t_result got);
        failures++;
        if (failures <= 10) begin
            $display("%0t %s", $realtime, what);
            $display("    expected: %s", result_text(want));
            $display("    actual:   %s", result_text(got));
        end
    endtask

    task automatic emit(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                        input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                        input logic [LEN_W-1:0] len, input logic last, input logic empty,
                        input logic [ROW_W-1:0] count);
        step_res[step_n] = '{kind: kind, content_byte: data, row_index: row,
                             column_index: col, field_length: len, last_in_row: last,
                             empty_row: empty, record_count: count, last_of_run: 1'b0};
        step_n++;
    endtask

    // Field end; a last field also closes the record
    task automatic close_field(input logic last);
        emit(KIND_FIELD_END, '0, row_q, col_q, kept_q, last, 1'b0, '0);
        kept_q = '0;
        if (last) begin
            col_q   = '0;
            row_q   = row_q + ROW_W'(1);
            phase_q = PH_RECORD;
        end else begin
            if (col_q != '1) col_q = col_q + COL_W'(1);
            phase_q = PH_FIELD;
        end
    endtask

    // Keep a byte unless the field is full; capacity 0 behaves as 1
    task automatic keep_byte(input logic [BYTE_W-1:0] b);
        int lim;
        lim = (cap_q == '0) ? 0 : int'(cap_q) - 1;
        if (lim > int'(KEEP_LIMIT_MAX)) lim = int'(KEEP_LIMIT_MAX);
        if (int'(kept_q) < lim) begin
            emit(KIND_CONTENT, b, row_q, col_q, '0, 1'b0, 1'b0, '0);
            kept_q = kept_q + LEN_W'(1);
        end
    endtask

    // Byte outside quotes, past the start of a field: delimiter checked first
    task automatic unquoted_byte(input logic [BYTE_W-1:0] b);
        if (b == delim_q) begin
            close_field(1'b0);
        end else if (b == CH_LF || b == CH_CR) begin
            close_field(1'b1);
            after_cr_q = (b == CH_CR);
        end else begin
            phase_q = PH_PLAIN;
            keep_byte(b);
        end
    endtask

    // Predict the results of one request
    task automatic parse_request(input logic [BYTE_W-1:0] b, input logic eot);
        step_n = 0;
        if (eot) begin
            if (phase_q != PH_RECORD) close_field(1'b1);
            emit(KIND_TEXT_DONE, '0, '0, '0, '0, 1'b0, 1'b0, row_q);
            row_q      = '0;
            col_q      = '0;
            kept_q     = '0;
            phase_q    = PH_RECORD;
            after_cr_q = 1'b0;
            return;
        end
        // LF straight after a terminating CR is swallowed
        if (after_cr_q) begin
            after_cr_q = 1'b0;
            if (b == CH_LF) return;
        end
        case (phase_q)
            PH_FIELD: begin
                if (b == CH_QUOTE) phase_q = PH_QUOTED;
                else unquoted_byte(b);
            end
            PH_PLAIN: begin
                unquoted_byte(b);
            end
            PH_QUOTED: begin
                if (b == CH_QUOTE) phase_q = PH_QSEEN;
                else keep_byte(b);
            end
            PH_QSEEN: begin
                // doubled quote is a literal one, anything else ends quoting
                if (b == CH_QUOTE) begin
                    phase_q = PH_QUOTED;
                    keep_byte(CH_QUOTE);
                end else begin
                    phase_q = PH_PLAIN;
                    unquoted_byte(b);
                end
            end
            default: begin
                // record start: CR or LF here is a blank line
                phase_q = PH_RECORD;
                if (b == CH_LF || b == CH_CR) begin
                    emit(KIND_FIELD_END, '0, row_q, '0, '0, 1'b1, 1'b1, '0);
                    row_q      = row_q + ROW_W'(1);
                    col_q      = '0;
                    kept_q     = '0;
                    after_cr_q = (b == CH_CR);
                end else if (b == CH_QUOTE) begin
                    phase_q = PH_QUOTED;
                end else begin
                    unquoted_byte(b);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            phase_q    = PH_RECORD;
            after_cr_q = 1'b0;
            row_q      = '0;
            col_q      = '0;
            kept_q     = '0;
            delim_q    = DELIMITER_RST;
            cap_q      = CAP_W'(KEEP_LIMIT_RST) + CAP_W'(1);
            owed_results.delete();
        end else begin
            // Compare an accepted result with the oldest one owed
            if (i_out_valid && !i_out_stall) begin
                got = '{kind: i_kind, content_byte: i_content_byte, row_index: i_row_index,
                        column_index: i_column_index, field_length: i_field_length,
                        last_in_row: i_last_in_row, empty_row: i_empty_row,
                        record_count: i_record_count, last_of_run: i_last_of_run};
                if (owed_results.size() == 0) begin
                    report_failure("result with nothing expected", '0, got);
                end else begin
                    want = owed_results.pop_front();
                    if (got !== want) report_failure("result mismatch", want, got);
                end
            end
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DELIMITER:      delim_q = i_cfg_data[BYTE_W-1:0];
                    CFG_FIELD_CAPACITY: cap_q   = i_cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            end
            // Accepted request
            if (i_in_valid && !i_in_stall) begin
                parse_request(i_text_byte, i_end_of_text);
                for (int k = 0; k < step_n; k++) begin
                    want = step_res[k];
                    want.last_of_run = (k == step_n - 1);
                    owed_results.push_back(want);
                end
            end
        end
        o_pending    <= owed_results.size();
        o_fail_count <= failures;
    end

endmodule

/* tb/sv/tb_csv_field_parser.sv */
module tb_csv_field_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import csvp_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [BYTE_W-1:0]      text_byte = '0;
    logic                   end_of_text = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [KIND_W-1:0]      kind;
    logic [BYTE_W-1:0]      content_byte;
    logic [ROW_W-1:0]       row_index;
    logic [ROW_W-1:0]       record_count;
    logic [COL_W-1:0]       column_index;
    logic [LEN_W-1:0]       field_length;
    logic                   last_in_row;
    logic                   empty_row;
    logic                   last_of_run;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DAT_W-1:0]   cfg_data = '0;

    int                     fail_count;
    int                     pending;
    int                     idle_pct = 22;
    int                     sent = 0;
    int                     idle_cycles = 0;
    logic [BYTE_W-1:0]      delim_now = DELIMITER_RST;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    csv_field_parser i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_text_byte    (text_byte),
        .i_end_of_text  (end_of_text),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_kind         (kind),
        .o_content_byte (content_byte),
        .o_row_index    (row_index),
        .o_column_index (column_index),
        .o_field_length (field_length),
        .o_last_in_row  (last_in_row),
        .o_empty_row    (empty_row),
        .o_record_count (record_count),
        .o_last_of_run  (last_of_run),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    csv_field_parser_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_text_byte    (text_byte),
        .i_end_of_text  (end_of_text),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_kind         (kind),
        .i_content_byte (content_byte),
        .i_row_index    (row_index),
        .i_column_index (column_index),
        .i_field_length (field_length),
        .i_last_in_row  (last_in_row),
        .i_empty_row    (empty_row),
        .i_record_count (record_count),
        .i_last_of_run  (last_of_run),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Receiver stalls at random
    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(0, 99) < idle_pct);
    end

    // Watchdog: too long without any request, result or register write
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL csv_field_parser");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One request, with random gaps ahead of it; returns once it is taken
    task automatic send_request(input logic [BYTE_W-1:0] b, input logic eot);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Ordinary field byte: none of delimiter, CR, LF or quote
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom);
        while (b == delim_now || b == CH_CR || b == CH_LF || b == CH_QUOTE);
        return b;
    endfunction

    // Any byte, with the special ones favoured
    function automatic logic [BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 9))
            0:       return delim_now;
            1:       return CH_CR;
            2:       return CH_LF;
            3:       return CH_QUOTE;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Well-formed record with random content; zero fields makes a blank line
    task automatic send_record();
        int n_fields;
        int len;
        logic [BYTE_W-1:0] b;
        n_fields = $urandom_range(0, 4);
        for (int f = 0; f < n_fields; f++) begin
            if (f != 0) send_request(delim_now, 1'b0);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 5);
            if ($urandom_range(0, 2) == 0) begin
                // quoted: may hold delimiter, CR, LF; quotes are doubled
                send_request(CH_QUOTE, 1'b0);
                for (int i = 0; i < len; i++) begin
                    b = noise_byte();
                    if (b == CH_QUOTE) send_request(CH_QUOTE, 1'b0);
                    send_request(b, 1'b0);
                end
                send_request(CH_QUOTE, 1'b0);
                // stray bytes after the closing quote
                if ($urandom_range(0, 5) == 0) send_request(plain_byte(), 1'b0);
            end else begin
                for (int i = 0; i < len; i++) send_request(plain_byte(), 1'b0);
            end
        end
        case ($urandom_range(0, 3))
            0: send_request(CH_CR, 1'b0);
            1: begin
                send_request(CH_CR, 1'b0);
                send_request(CH_LF, 1'b0);
            end
            default: send_request(CH_LF, 1'b0);
        endcase
    endtask

    // Configure, then mostly records, some noise and early text ends
    task automatic run_phase(input logic [BYTE_W-1:0] d, input logic [CAP_W-1:0] cap,
                             input int n_items);
        int target;
        int sel;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DELIMITER;
        cfg_data  <= CFG_DAT_W'(d);
        @(posedge clk);
        cfg_index <= CFG_FIELD_CAPACITY;
        cfg_data  <= CFG_DAT_W'(cap);
        @(posedge clk);
        cfg_we    <= 1'b0;
        delim_now = d;
        target = sent + n_items;
        while (sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) send_record();
            else if (sel < 92) repeat ($urandom_range(1, 6)) send_request(noise_byte(), 1'b0);
            else send_request(BYTE_W'($urandom), 1'b1);
        end
        send_request(BYTE_W'($urandom), 1'b1);
        wait_until_idle();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text at reset settings: doubled quote, bytes after a closing
        // quote, extreme bytes, CRLF, blank LF line, unterminated quote at end
        send_request(CH_QUOTE, 1'b0);
        send_request("a", 1'b0);
        send_request(CH_QUOTE, 1'b0);
        send_request(CH_QUOTE, 1'b0);
        send_request("b", 1'b0);
        send_request(CH_QUOTE, 1'b0);
        send_request("z", 1'b0);
        send_request(DELIMITER_RST, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(CH_CR, 1'b0);
        send_request(CH_LF, 1'b0);
        send_request(CH_LF, 1'b0);
        send_request(CH_QUOTE, 1'b0);
        send_request("x", 1'b0);
        send_request(DELIMITER_RST, 1'b0);
        send_request(CH_LF, 1'b0);
        send_request(8'h00, 1'b1);
        // trailing delimiter at end of text, then CR blank line and a lone CR
        send_request("a", 1'b0);
        send_request(DELIMITER_RST, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(CH_CR, 1'b0);
        send_request("b", 1'b0);
        send_request(CH_CR, 1'b0);
        send_request("c", 1'b1);
        wait_until_idle();

        run_phase(DELIMITER_RST, CAP_W'(KEEP_LIMIT_RST) + CAP_W'(1), 300);
        run_phase(8'd0, 13'd0, 250);
        run_phase(8'd255, 13'd1, 250);
        // stretch with no idling on either side
        idle_pct = 0;
        run_phase(CH_QUOTE, 13'd3, 250);
        idle_pct = 22;
        run_phase(CH_CR, 13'd8191, 200);
        run_phase(CH_LF, 13'd4096, 200);
        run_phase(BYTE_W'($urandom), CAP_W'($urandom_range(2, 12)), 300);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS csv_field_parser");
        end else begin
            $display("FAIL csv_field_parser");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/csvp_pkg.sv
rtl/csvp_core.sv
rtl/csvp_outq.sv
rtl/csv_field_parser.sv
tb/sv/csv_field_parser_checker.sv
tb/sv/tb_csv_field_parser.sv
